/* hdl/gsa_pkg.sv */
// Package for the generational slot allocator: sizes, operation and status codes,
// request and response beat types, and the controller command struct.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gsa_pkg;

  localparam int SLOTS           = 256;
  localparam int COMPONENT_KINDS = 8;
  localparam int GEN_BITS        = 8;

  localparam int SLOT_W  = $clog2(SLOTS);
  // Free-list head and live count both need to hold SLOTS itself.
  localparam int HEAD_W  = $clog2(SLOTS + 1);
  localparam int MASK_W  = COMPONENT_KINDS;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 3;

  localparam logic [OPCODE_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DESTROY = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_ADD     = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_QUERY   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STALE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd4;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [HEAD_W-1:0]   head_t;
  typedef logic [GEN_BITS-1:0] gen_t;
  typedef logic [MASK_W-1:0]   mask_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] slot_index;
    logic [7:0] handle_generation;
    logic [2:0] component_kind;
  } gsa_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_slot;
    logic [7:0] out_generation;
    logic [7:0] component_mask;
    logic [8:0] live_total;
  } gsa_rsp_t;

  // capture: latch the request and launch the table reads.
  // commit: update the tables and load the response register.
  typedef struct packed {
    logic capture;
    logic commit;
  } gsa_cmd_t;

endpackage

`default_nettype wire

/* hdl/gsa_ctrl.sv */
// Controller for the generational slot allocator: a two-state sequencer that
// launches the table read and then the commit of each request.
// Depends on gsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsa_ctrl
  import gsa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output      logic     busy_o,
  output      logic     valid_o,
  output      gsa_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= cmd_o.commit;
    end
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;

`ifndef SYNTHESIS
  a_capture_then_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.commit)
    else $error("capture not followed by commit");

  a_valid_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(cmd_o.commit))
    else $error("result strobe without a commit");

  a_free_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("busy while a result is shown");
`endif

endmodule

`default_nettype wire

/* hdl/gsa_datapath.sv */
// Datapath of the generational slot allocator: slot tables (generation, free
// link, component mask), live and used bits, free-list head, live count and
// the response register. Depends on gsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsa_datapath
  import gsa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire gsa_cmd_t cmd_i,
  input  wire gsa_req_t req_i,
  output      gsa_rsp_t rsp_o
);

  gen_t  gen_mem_q  [SLOTS];
  head_t link_mem_q [SLOTS];
  mask_t mask_mem_q [SLOTS];

  // used_q marks slots allocated at least once; until then the generation
  // reads as zero and the free link as the following slot.
  logic [SLOTS-1:0] live_q, used_q;
  head_t            head_q, head_d;
  head_t            count_q, count_d;

  gsa_req_t req_q;
  slot_t    addr_q, rd_addr;
  gen_t     gen_rd_q;
  head_t    link_rd_q;
  mask_t    mask_rd_q;
  logic     live_rd_q, used_rd_q;
  gsa_rsp_t rsp_q;

  gen_t     gen_cur, gen_wd;
  head_t    link_cur;
  mask_t    kind_bit, mask_wd;
  logic     idx_ok, kind_ok, handle_ok, full;
  logic     gen_we, link_we, mask_we, live_set, live_clr;
  gsa_rsp_t rsp_d;

  assign rd_addr = (req_i.opcode == OP_CREATE) ? head_q[SLOT_W-1:0]
                                               : req_i.slot_index[SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_i;
      addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_we) gen_mem_q[addr_q] <= gen_wd;
    if (cmd_i.capture) gen_rd_q <= gen_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem_q[addr_q] <= head_q;
    if (cmd_i.capture) link_rd_q <= link_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mask_we) mask_mem_q[addr_q] <= mask_wd;
    if (cmd_i.capture) mask_rd_q <= mask_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      live_rd_q <= live_q[rd_addr];
      used_rd_q <= used_q[rd_addr];
    end
  end

  always_comb begin
    gen_cur   = used_rd_q ? gen_rd_q : '0;
    link_cur  = used_rd_q ? link_rd_q : head_t'(addr_q) + head_t'(1);
    gen_wd    = gen_cur + gen_t'(1);
    kind_bit  = mask_t'(1) << req_q.component_kind;
    idx_ok    = int'(req_q.slot_index) < SLOTS;
    kind_ok   = int'(req_q.component_kind) < COMPONENT_KINDS;
    handle_ok = idx_ok && live_rd_q &&
                (gen_cur == gen_t'(req_q.handle_generation));
    full      = (int'(head_q) >= SLOTS) || (int'(count_q) >= SLOTS);

    gen_we   = 1'b0;
    link_we  = 1'b0;
    mask_we  = 1'b0;
    mask_wd  = '0;
    live_set = 1'b0;
    live_clr = 1'b0;
    head_d   = head_q;
    count_d  = count_q;

    rsp_d.status         = ST_STALE;
    rsp_d.out_slot       = req_q.slot_index;
    rsp_d.out_generation = '0;
    rsp_d.component_mask = '0;

    if (req_q.opcode == OP_CREATE) begin
      if (full) begin
        rsp_d.status = ST_FULL;
      end else begin
        gen_we   = 1'b1;
        mask_we  = 1'b1;
        live_set = 1'b1;
        head_d   = link_cur;
        count_d  = count_q + head_t'(1);
        rsp_d.status         = ST_OK;
        rsp_d.out_slot       = 8'(addr_q);
        rsp_d.out_generation = 8'(gen_wd);
      end
    end else if (handle_ok) begin
      rsp_d.out_generation = 8'(gen_cur);
      rsp_d.component_mask = 8'(mask_rd_q);
      case (req_q.opcode)
        OP_DESTROY: begin
          link_we  = 1'b1;
          live_clr = 1'b1;
          head_d   = head_t'(addr_q);
          count_d  = count_q - head_t'(1);
          rsp_d.status         = ST_OK;
          rsp_d.component_mask = '0;
        end
        OP_QUERY: begin
          rsp_d.status = ST_OK;
        end
        OP_ADD: begin
          if (!kind_ok) begin
            rsp_d.status = ST_ABSENT;
          end else if ((mask_rd_q & kind_bit) != '0) begin
            rsp_d.status = ST_PRESENT;
          end else begin
            mask_we = 1'b1;
            mask_wd = mask_rd_q | kind_bit;
            rsp_d.status         = ST_OK;
            rsp_d.component_mask = 8'(mask_wd);
          end
        end
        OP_REMOVE: begin
          if (!kind_ok || ((mask_rd_q & kind_bit) == '0)) begin
            rsp_d.status = ST_ABSENT;
          end else begin
            mask_we = 1'b1;
            mask_wd = mask_rd_q & ~kind_bit;
            rsp_d.status         = ST_OK;
            rsp_d.component_mask = 8'(mask_wd);
          end
        end
        default: begin
          // Unknown opcodes answer as a stale handle.
          rsp_d.status         = ST_STALE;
          rsp_d.out_generation = '0;
          rsp_d.component_mask = '0;
        end
      endcase
    end

    rsp_d.live_total = 9'(count_d);

    if (!cmd_i.commit) begin
      gen_we   = 1'b0;
      link_we  = 1'b0;
      mask_we  = 1'b0;
      live_set = 1'b0;
      live_clr = 1'b0;
      head_d   = head_q;
      count_d  = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= '0;
      used_q  <= '0;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      if (live_set) begin
        live_q[addr_q] <= 1'b1;
        used_q[addr_q] <= 1'b1;
      end
      if (live_clr) live_q[addr_q] <= 1'b0;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= SLOTS)
    else $error("live count above table size");

  a_empty_list_iff_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(head_q) == SLOTS) == (int'(count_q) == SLOTS))
    else $error("free list and live count disagree");

  a_create_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && live_set) |=> (count_q == $past(count_q) + head_t'(1)))
    else $error("create did not bump the live count");
`endif

endmodule

`default_nettype wire

/* hdl/generational_slot_allocator_core.sv */
// Top level of the generational slot allocator: joins the controller and the
// datapath. Depends on gsa_pkg, gsa_ctrl and gsa_datapath.
//
//   channel   signals                      handshake
//   request   start, busy, req_i           taken when start is high and busy is low
//   response  result_valid_o, rsp_o        one cycle per beat, cannot be stalled
//
// Each request is taken in the idle state, where the slot tables are read, and
// is then committed in the execute state, where they are updated; a new beat
// can be taken once the controller is back in idle. The response shows the cycle
// after the update, while the next beat can already be taken. Reset clears the state;
// the tables need no clearing pass. The receiver cannot stall responses.
`timescale 1ns / 1ps
`default_nettype none

module generational_slot_allocator_core
  import gsa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output      logic     busy,
  input  wire gsa_req_t req_i,
  output      logic     result_valid_o,
  output      gsa_rsp_t rsp_o
);

  gsa_cmd_t cmd;

  gsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .valid_o (result_valid_o),
    .cmd_o   (cmd)
  );

  gsa_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for generational_slot_allocator_core: a scoreboard class
// tracks the slot table and free list and checks every response beat in order.
// Depends on gsa_pkg and the allocator RTL.
`timescale 1ns / 1ps

import gsa_pkg::*;

class slot_map_scoreboard;
  bit       live [SLOTS];
  gen_t     slot_gen [SLOTS];
  mask_t    slot_mask [SLOTS];
  head_t    next_link [SLOTS];
  head_t    free_head;
  head_t    live_count;
  gsa_rsp_t expected_rsp [$];
  bit       last_alloc_ok;
  slot_t    last_alloc_slot;
  int       errors;
  int       requests;
  int       responses;
  int       gen_wraps;
  int       peak_live;
  int       status_seen [8];

  function new();
    free_head = '0;
    live_count = '0;
    for (int i = 0; i < SLOTS; i++) begin
      live[i] = 1'b0;
      slot_gen[i] = '0;
      slot_mask[i] = '0;
      next_link[i] = head_t'(i + 1);
    end
    for (int i = 0; i < 8; i++) begin
      status_seen[i] = 0;
    end
    errors = 0;
    requests = 0;
    responses = 0;
    gen_wraps = 0;
    peak_live = 0;
    last_alloc_ok = 1'b0;
    last_alloc_slot = '0;
  endfunction

  function bit handle_valid(gsa_req_t r);
    return int'(r.slot_index) < SLOTS && live[r.slot_index]
      && slot_gen[r.slot_index] == r.handle_generation;
  endfunction

  // Applies one request to the tracked table and returns the response it should give.
  function gsa_rsp_t table_update(gsa_req_t r);
    gsa_rsp_t rsp;
    slot_t    s;
    mask_t    kind_bit;
    rsp = '0;
    rsp.out_slot = r.slot_index;
    last_alloc_ok = 1'b0;
    if (r.opcode == OP_CREATE) begin
      if (free_head >= SLOTS || live_count >= SLOTS || live[free_head[SLOT_W-1:0]]) begin
        rsp.status = ST_FULL;
      end else begin
        s = free_head[SLOT_W-1:0];
        free_head = next_link[s];
        slot_gen[s] = slot_gen[s] + 1'b1;
        if (slot_gen[s] == '0) gen_wraps++;
        slot_mask[s] = '0;
        live[s] = 1'b1;
        live_count++;
        rsp.status = ST_OK;
        rsp.out_slot = s;
        rsp.out_generation = slot_gen[s];
        last_alloc_ok = 1'b1;
        last_alloc_slot = s;
      end
    end else if (r.opcode > OP_QUERY || !handle_valid(r)) begin
      rsp.status = ST_STALE;
    end else begin
      s = r.slot_index;
      rsp.status = ST_OK;
      rsp.out_generation = slot_gen[s];
      case (r.opcode)
        OP_DESTROY: begin
          slot_mask[s] = '0;
          live[s] = 1'b0;
          next_link[s] = free_head;
          free_head = head_t'(s);
          live_count--;
        end
        OP_ADD, OP_REMOVE: begin
          kind_bit = mask_t'(1) << r.component_kind;
          if (int'(r.component_kind) >= COMPONENT_KINDS) begin
            rsp.status = ST_ABSENT;
          end else if (r.opcode == OP_ADD && (slot_mask[s] & kind_bit) != '0) begin
            rsp.status = ST_PRESENT;
          end else if (r.opcode == OP_REMOVE && (slot_mask[s] & kind_bit) == '0) begin
            rsp.status = ST_ABSENT;
          end else if (r.opcode == OP_ADD) begin
            slot_mask[s] = slot_mask[s] | kind_bit;
          end else begin
            slot_mask[s] = slot_mask[s] & ~kind_bit;
          end
        end
        default: ;
      endcase
      rsp.component_mask = slot_mask[s];
    end
    rsp.live_total = live_count;
    if (int'(live_count) > peak_live) peak_live = int'(live_count);
    return rsp;
  endfunction

  function void note_request(gsa_req_t r);
    requests++;
    expected_rsp.push_back(table_update(r));
  endfunction

  function void compare_field(string name, logic [8:0] want_v, logic [8:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  function void check_response(gsa_rsp_t got);
    gsa_rsp_t want;
    responses++;
    if (expected_rsp.size() == 0) begin
      $display("%0t ns: response beat with nothing expected, got %p", $time, got);
      errors++;
      return;
    end
    want = expected_rsp.pop_front();
    status_seen[want.status]++;
    compare_field("status", want.status, got.status);
    compare_field("out_slot", want.out_slot, got.out_slot);
    compare_field("out_generation", want.out_generation, got.out_generation);
    compare_field("component_mask", want.component_mask, got.component_mask);
    compare_field("live_total", want.live_total, got.live_total);
  endfunction

  // Returns some live slot, scanning from a random point.
  function bit pick_live(output slot_t idx);
    int first;
    idx = '0;
    if (live_count == '0) return 1'b0;
    first = $urandom_range(SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (live[(first + i) % SLOTS]) begin
        idx = slot_t'((first + i) % SLOTS);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction
endclass

module testbench;
  localparam logic [OPCODE_W-1:0] OP_BAD_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_BAD_LAST  = 3'd7;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  gsa_req_t req_i  = '0;
  logic     busy;
  logic     result_valid_o;
  gsa_rsp_t rsp_o;

  slot_map_scoreboard sb = new();
  int idle_pct = 0;
  bit fill_mode = 1'b1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  generational_slot_allocator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  // The receiver cannot hold responses off, so every strobed beat is checked.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      sb.check_response(rsp_o);
    end
  end

  task automatic send_beat(gsa_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(r);
  endtask

  task automatic send_op(logic [2:0] op, logic [7:0] idx, logic [7:0] g, logic [2:0] k);
    gsa_req_t r;
    r.opcode = op;
    r.slot_index = idx;
    r.handle_generation = g;
    r.component_kind = k;
    send_beat(r);
  endtask

  function automatic gsa_req_t random_fields(logic [2:0] op);
    gsa_req_t r;
    r.opcode = op;
    r.slot_index = 8'($urandom_range(255));
    r.handle_generation = 8'($urandom_range(255));
    r.component_kind = 3'($urandom_range(7));
    return r;
  endfunction

  // Mostly valid handles; the rest are stale generations, dead slots or noise.
  function automatic gsa_req_t handle_request(logic [2:0] op);
    gsa_req_t r;
    slot_t    idx;
    int       pick;
    r = random_fields(op);
    pick = $urandom_range(99);
    if (pick < 78 && sb.pick_live(idx)) begin
      r.slot_index = idx;
      r.handle_generation = sb.slot_gen[idx];
    end else if (pick < 88 && sb.pick_live(idx)) begin
      r.slot_index = idx;
      r.handle_generation = sb.slot_gen[idx] + 8'($urandom_range(1, 255));
    end else if (pick < 94) begin
      r.handle_generation = sb.slot_gen[r.slot_index];
    end
    return r;
  endfunction

  function automatic gsa_req_t random_request();
    int pick;
    pick = $urandom_range(99);
    if (fill_mode) begin
      if (pick < 65) return random_fields(OP_CREATE);
      if (pick < 68) return handle_request(OP_DESTROY);
      if (pick < 80) return handle_request(OP_ADD);
      if (pick < 89) return handle_request(OP_REMOVE);
      if (pick < 95) return handle_request(OP_QUERY);
    end else begin
      if (pick < 6)  return random_fields(OP_CREATE);
      if (pick < 56) return handle_request(OP_DESTROY);
      if (pick < 74) return handle_request(OP_ADD);
      if (pick < 86) return handle_request(OP_REMOVE);
      if (pick < 95) return handle_request(OP_QUERY);
    end
    if (pick < 98) return handle_request(3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST)));
    return random_fields(3'($urandom_range(OP_BAD_LAST)));
  endfunction

  initial begin
    int phase_idle [4];
    int waited;
    phase_idle = '{0, 51, 0, 12};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: dead handles at reset, component bits at both ends, duplicate add,
    // absent remove, generation mismatch, unused opcodes, double destroy, LIFO reuse.
    send_op(OP_QUERY, 8'd0, 8'd0, 3'd0);
    send_op(OP_DESTROY, 8'd255, 8'd255, 3'd7);
    send_op(OP_CREATE, 8'd0, 8'd0, 3'd0);
    send_op(OP_CREATE, 8'd255, 8'd255, 3'd7);
    send_op(OP_ADD, 8'd0, 8'd1, 3'd0);
    send_op(OP_ADD, 8'd0, 8'd1, 3'd7);
    send_op(OP_ADD, 8'd0, 8'd1, 3'd7);
    send_op(OP_REMOVE, 8'd0, 8'd1, 3'd3);
    send_op(OP_REMOVE, 8'd0, 8'd1, 3'd0);
    send_op(OP_QUERY, 8'd0, 8'd1, 3'd0);
    send_op(OP_QUERY, 8'd0, 8'd2, 3'd0);
    send_op(OP_BAD_FIRST, 8'd0, 8'd1, 3'd0);
    send_op(OP_BAD_FIRST + 3'd1, 8'd0, 8'd1, 3'd0);
    send_op(OP_BAD_LAST, 8'd1, 8'd1, 3'd7);
    send_op(OP_DESTROY, 8'd0, 8'd1, 3'd0);
    send_op(OP_DESTROY, 8'd0, 8'd1, 3'd0);
    send_op(OP_ADD, 8'd0, 8'd1, 3'd2);
    send_op(OP_CREATE, 8'd17, 8'd0, 3'd0);
    send_op(OP_QUERY, 8'd0, 8'd2, 3'd0);
    send_op(OP_DESTROY, 8'd1, 8'd1, 3'd0);
    send_op(OP_QUERY, 8'd1, 8'd1, 3'd0);
    send_op(OP_CREATE, 8'd0, 8'd255, 3'd5);

    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      if (p == 3) begin
        // Create and destroy the same slot until its generation wraps past zero.
        repeat (260) begin
          send_beat(random_fields(OP_CREATE));
          if (sb.last_alloc_ok) begin
            send_op(OP_DESTROY, sb.last_alloc_slot, sb.slot_gen[sb.last_alloc_slot],
                    3'($urandom_range(7)));
          end else begin
            send_beat(handle_request(OP_DESTROY));
          end
        end
      end
      repeat (270) begin
        send_beat(random_request());
        if (fill_mode && sb.live_count == SLOTS && $urandom_range(5) == 0) begin
          fill_mode = 1'b0;
        end else if (!fill_mode && sb.live_count < 12) begin
          fill_mode = 1'b1;
        end
      end
    end
    start <= 1'b0;

    waited = 0;
    while (sb.expected_rsp.size() != 0 && waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.expected_rsp.size() != 0) begin
      $display("%0t ns: %0d expected responses never arrived", $time, sb.expected_rsp.size());
      sb.errors++;
    end
    $display("Sent %0d requests, checked %0d responses: %0d ok, %0d full, %0d stale,",
             sb.requests, sb.responses, sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
             sb.status_seen[ST_STALE]);
    $display("%0d already present, %0d absent; peak live %0d, generation wraps %0d.",
             sb.status_seen[ST_PRESENT], sb.status_seen[ST_ABSENT], sb.peak_live,
             sb.gen_wraps);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t ns: timeout with %0d responses outstanding", $time, sb.expected_rsp.size());
    $display("simulation failed");
    $finish;
  end
endmodule
